// ===== rtl/rmr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmr_pkg
// Shared widths, latencies and beat types for the rotation matrix
// renormalize unit. Entries are signed Q2.14.
// ----------------------------------------------------------------------------
package rmr_pkg;

    localparam int ENTRY_W   = 16;
    localparam int FRAC_W    = ENTRY_W - 2;
    localparam int PROD_W    = 2 * ENTRY_W;        // entry x entry
    localparam int CROSS_W   = PROD_W + 1;         // cross product component
    localparam int MAG_W     = CROSS_W - 1;        // its magnitude
    localparam int POS_W     = $clog2(MAG_W);
    localparam int NORM_W    = 30;                 // largest magnitude in [2^29, 2^30)
    localparam int SQ_W      = 2 * NORM_W;
    localparam int SUM_W     = SQ_W + 2;
    localparam int ROOT_W    = SUM_W / 2;
    localparam int RAD_W     = SUM_W + 1;
    localparam int QUO_W     = FRAC_W + 1;
    localparam int NUM_W     = NORM_W + FRAC_W + 1;
    localparam int DOT_W     = PROD_W + 2;

    localparam int UNIT_LAT  = 5 + ROOT_W + 1 + QUO_W + 1;
    localparam int PHASE_LAT = UNIT_LAT + 4;
    localparam int TOTAL_LAT = 3 * PHASE_LAT + 2;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_KEEP_X = 2'd1,
        MODE_KEEP_Y = 2'd2,
        MODE_KEEP_Z = 2'd3
    } t_mode;

    typedef logic signed [ENTRY_W-1:0] t_entry;
    typedef logic [2:0][ENTRY_W-1:0]   t_vec;
    typedef logic [2:0][CROSS_W-1:0]   t_wide_vec;
    typedef t_vec [2:0]                t_mtx;

    typedef struct packed {
        logic do_cross;
        logic do_fix;
    } t_ph_ctl;

    typedef struct packed {
        t_mode mode;
        t_mtx  mtx;
    } t_carry;

    typedef struct packed {
        t_mode  mode;
        t_entry in_r0c0;
        t_entry in_r0c1;
        t_entry in_r0c2;
        t_entry in_r1c0;
        t_entry in_r1c1;
        t_entry in_r1c2;
        t_entry in_r2c0;
        t_entry in_r2c1;
        t_entry in_r2c2;
    } t_rmr_in;

    typedef struct packed {
        t_entry out_r0c0;
        t_entry out_r0c1;
        t_entry out_r0c2;
        t_entry out_r1c0;
        t_entry out_r1c1;
        t_entry out_r1c2;
        t_entry out_r2c0;
        t_entry out_r2c1;
        t_entry out_r2c2;
    } t_rmr_out;

endpackage
`default_nettype wire

// ===== rtl/rotation_matrix_renormalize_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_renormalize_unit
// Orthonormalizes a nearly orthonormal 3x3 frame (three Q2.14 rows) with
// an optional preserved axis. Three chained rebuild phases, each an optional
// cross product, a normalizer and an optional direction check.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake              beat
//  -------   ---   --------------------   -------------------------------
//  command   in    start high, busy low   mode + nine input entries
//  result    out   o_strobe, one cycle    nine renormalized entries
//
// One beat may enter every cycle; busy never rises.
// Pipeline: input register, three phases of 57 stages each, output
// register. Each phase is dominated by the 31-stage square root and the
// 15-stage divider.
// Reset (synchronous) clears only the valid bits; in-flight beats are dropped.
// No stall path: the result strobe cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module rotation_matrix_renormalize_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  rmr_pkg::t_rmr_in  i_cmd,
    output logic              o_strobe,
    output rmr_pkg::t_rmr_out o_res
);
    import rmr_pkg::*;

    typedef enum logic [1:0] {
        ROW_X = 2'd0,
        ROW_Y = 2'd1,
        ROW_Z = 2'd2
    } t_row_sel;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } t_phase;

    typedef struct packed {
        t_row_sel a;
        t_row_sel b;
        t_row_sel old;
        t_row_sel dst;
        t_ph_ctl  ctl;
    } t_route;

    // Which rows feed each phase, and which row it rewrites.
    function automatic t_route route(input t_mode m, input t_phase ph);
        t_route rt;
        rt = '{a: ROW_X, b: ROW_Y, old: ROW_Z, dst: ROW_Z,
               ctl: '{do_cross: 1'b1, do_fix: 1'b1}};
        case (ph)
            PH_FIRST: begin
                case (m)
                    MODE_NONE: begin
                        rt.a = ROW_Z; rt.b = ROW_X; rt.old = ROW_Y; rt.dst = ROW_Y;
                    end
                    MODE_KEEP_X: begin
                        rt.a = ROW_X; rt.b = ROW_X; rt.old = ROW_X; rt.dst = ROW_X;
                        rt.ctl = '{do_cross: 1'b0, do_fix: 1'b0};
                    end
                    MODE_KEEP_Y: begin
                        rt.a = ROW_Y; rt.b = ROW_Y; rt.old = ROW_Y; rt.dst = ROW_Y;
                        rt.ctl = '{do_cross: 1'b0, do_fix: 1'b0};
                    end
                    default: begin
                        rt.a = ROW_Z; rt.b = ROW_Z; rt.old = ROW_Z; rt.dst = ROW_Z;
                        rt.ctl = '{do_cross: 1'b0, do_fix: 1'b0};
                    end
                endcase
            end
            PH_SECOND: begin
                case (m)
                    MODE_NONE: begin
                        rt.a = ROW_Z; rt.b = ROW_Y; rt.old = ROW_X; rt.dst = ROW_X;
                    end
                    MODE_KEEP_X: begin
                        rt.a = ROW_X; rt.b = ROW_Z; rt.old = ROW_Y; rt.dst = ROW_Y;
                    end
                    default: begin
                        rt.a = ROW_Y; rt.b = ROW_Z; rt.old = ROW_X; rt.dst = ROW_X;
                    end
                endcase
            end
            default: begin
                if (m == MODE_KEEP_Z) begin
                    rt.a = ROW_X; rt.b = ROW_Z; rt.old = ROW_Y; rt.dst = ROW_Y;
                end else begin
                    rt.a = ROW_X; rt.b = ROW_Y; rt.old = ROW_Z; rt.dst = ROW_Z;
                end
            end
        endcase
        return rt;
    endfunction

    // input register
    t_carry n_in, r_in;
    logic   r_in_v;

    always_comb begin
        n_in.mode      = i_cmd.mode;
        n_in.mtx[0][0] = i_cmd.in_r0c0;
        n_in.mtx[0][1] = i_cmd.in_r0c1;
        n_in.mtx[0][2] = i_cmd.in_r0c2;
        n_in.mtx[1][0] = i_cmd.in_r1c0;
        n_in.mtx[1][1] = i_cmd.in_r1c1;
        n_in.mtx[1][2] = i_cmd.in_r1c2;
        n_in.mtx[2][0] = i_cmd.in_r2c0;
        n_in.mtx[2][1] = i_cmd.in_r2c1;
        n_in.mtx[2][2] = i_cmd.in_r2c2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else begin
            r_in_v <= start && !busy;
        end
        r_in <= n_in;
    end

    // phase chain; the matrix and mode ride along each phase
    t_carry car_s [4];
    logic   vld_s [4];

    assign car_s[0] = r_in;
    assign vld_s[0] = r_in_v;

    for (genvar g = 0; g < 3; g++) begin : g_phase
        localparam t_phase PH = t_phase'(g);
        t_route                     rt_in;
        t_route                     rt_out;
        logic                       ph_v;
        t_vec                       ph_vec;
        logic [$bits(t_carry)-1:0]  ph_raw;
        t_carry                     done;
        t_carry                     merged;

        assign rt_in = route(car_s[g].mode, PH);

        rmr_phase #(
            .SIDE_W ($bits(t_carry))
        ) u_phase (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (vld_s[g]),
            .i_a     (car_s[g].mtx[rt_in.a]),
            .i_b     (car_s[g].mtx[rt_in.b]),
            .i_old   (car_s[g].mtx[rt_in.old]),
            .i_ctl   (rt_in.ctl),
            .i_side  (car_s[g]),
            .o_valid (ph_v),
            .o_vec   (ph_vec),
            .o_side  (ph_raw)
        );

        assign done   = t_carry'(ph_raw);
        assign rt_out = route(done.mode, PH);

        always_comb begin
            merged                 = done;
            merged.mtx[rt_out.dst] = ph_vec;
        end

        assign car_s[g+1] = merged;
        assign vld_s[g+1] = ph_v;
    end

    // output register
    t_mtx r_out;
    logic r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= vld_s[3];
        end
        r_out <= car_s[3].mtx;
    end

    assign busy     = 1'b0;
    assign o_strobe = r_out_v;

    assign o_res.out_r0c0 = r_out[0][0];
    assign o_res.out_r0c1 = r_out[0][1];
    assign o_res.out_r0c2 = r_out[0][2];
    assign o_res.out_r1c0 = r_out[1][0];
    assign o_res.out_r1c1 = r_out[1][1];
    assign o_res.out_r1c2 = r_out[1][2];
    assign o_res.out_r2c0 = r_out[2][0];
    assign o_res.out_r2c1 = r_out[2][1];
    assign o_res.out_r2c2 = r_out[2][2];

    // every unit-vector entry lies within +-1.0
    logic res_in_range;

    always_comb begin
        logic signed [ENTRY_W-1:0] e;
        res_in_range = 1'b1;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                e = $signed(r_out[r][c]);
                if (e > $signed(ENTRY_W'(1) << FRAC_W) ||
                    e < -$signed(ENTRY_W'(1) << FRAC_W)) begin
                    res_in_range = 1'b0;
                end
            end
        end
    end

    a_beat_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##TOTAL_LAT o_strobe)
        else $error("accepted beat did not come out after the pipeline latency");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, TOTAL_LAT))
        else $error("result strobe without a matching accepted beat");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> res_in_range)
        else $error("result entry beyond +-1.0");

endmodule
`default_nettype wire

// ===== rtl/rmr_isqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmr_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rmr_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [rmr_pkg::SUM_W-1:0]  i_sum,
    input  logic [SIDE_W-1:0]          i_side,
    output logic                       o_valid,
    output logic [rmr_pkg::ROOT_W-1:0] o_root,
    output logic [SIDE_W-1:0]          o_side
);
    import rmr_pkg::*;

    logic              vld_s  [ROOT_W+1];
    logic [SUM_W-1:0]  rem_s  [ROOT_W];
    logic [RAD_W-1:0]  rad_s  [ROOT_W+1];
    logic [SIDE_W-1:0] side_s [ROOT_W+1];

    assign vld_s[0]  = i_valid;
    assign rem_s[0]  = i_sum;
    assign rad_s[0]  = '0;
    assign side_s[0] = i_side;

    for (genvar g = 0; g < ROOT_W; g++) begin : g_step
        localparam int SH = 2 * (ROOT_W - 1 - g);
        logic [RAD_W-1:0]  bitv;
        logic [RAD_W-1:0]  trial;
        logic [RAD_W-1:0]  n_rad;
        logic [RAD_W-1:0]  r_rad;
        logic              take;
        logic              r_vld;
        logic [SIDE_W-1:0] r_side;

        assign bitv  = RAD_W'(1) << SH;
        assign trial = rad_s[g] + bitv;
        assign take  = {1'b0, rem_s[g]} >= trial;
        assign n_rad = take ? (rad_s[g] >> 1) + bitv : rad_s[g] >> 1;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= vld_s[g];
            end
            r_rad  <= n_rad;
            r_side <= side_s[g];
        end

        assign vld_s[g+1]  = r_vld;
        assign rad_s[g+1]  = r_rad;
        assign side_s[g+1] = r_side;

        if (g < ROOT_W - 1) begin : g_rem
            logic [SUM_W-1:0] n_rem;
            logic [SUM_W-1:0] r_rem;
            assign n_rem = take ? rem_s[g] - trial[SUM_W-1:0] : rem_s[g];
            always_ff @(posedge i_clk) begin
                r_rem <= n_rem;
            end
            assign rem_s[g+1] = r_rem;
        end
    end

    assign o_valid = vld_s[ROOT_W];
    assign o_root  = rad_s[ROOT_W][ROOT_W-1:0];
    assign o_side  = side_s[ROOT_W];

endmodule
`default_nettype wire

// ===== rtl/rmr_divide.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmr_divide
// Three-lane pipelined restoring divider sharing one divisor, one
// quotient bit per stage.
// ----------------------------------------------------------------------------
module rmr_divide #(
    parameter int SIDE_W = 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [2:0][rmr_pkg::NUM_W-1:0]      i_num,
    input  logic [rmr_pkg::ROOT_W-1:0]          i_den,
    input  logic [SIDE_W-1:0]                   i_side,
    output logic                                o_valid,
    output logic [2:0][rmr_pkg::QUO_W-1:0]      o_quo,
    output logic [SIDE_W-1:0]                   o_side
);
    import rmr_pkg::*;

    logic                   vld_s  [QUO_W+1];
    logic [2:0][NUM_W-1:0]  rem_s  [QUO_W];
    logic [ROOT_W-1:0]      den_s  [QUO_W];
    logic [2:0][QUO_W-1:0]  quo_s  [QUO_W+1];
    logic [SIDE_W-1:0]      side_s [QUO_W+1];

    assign vld_s[0]  = i_valid;
    assign rem_s[0]  = i_num;
    assign den_s[0]  = i_den;
    assign quo_s[0]  = '0;
    assign side_s[0] = i_side;

    for (genvar g = 0; g < QUO_W; g++) begin : g_step
        localparam int SH = QUO_W - 1 - g;
        logic [NUM_W:0]        dsh;
        logic [2:0]            take;
        logic [2:0][QUO_W-1:0] n_quo;
        logic [2:0][QUO_W-1:0] r_quo;
        logic                  r_vld;
        logic [SIDE_W-1:0]     r_side;

        assign dsh = {(NUM_W + 1 - ROOT_W)'(0), den_s[g]} << SH;

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                take[l]      = {1'b0, rem_s[g][l]} >= dsh;
                n_quo[l]     = quo_s[g][l];
                n_quo[l][SH] = take[l];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= vld_s[g];
            end
            r_quo  <= n_quo;
            r_side <= side_s[g];
        end

        assign vld_s[g+1]  = r_vld;
        assign quo_s[g+1]  = r_quo;
        assign side_s[g+1] = r_side;

        if (g < QUO_W - 1) begin : g_rem
            logic [2:0][NUM_W-1:0] n_rem;
            logic [2:0][NUM_W-1:0] r_rem;
            logic [ROOT_W-1:0]     r_den;
            always_comb begin
                for (int l = 0; l < 3; l++) begin
                    n_rem[l] = take[l] ? rem_s[g][l] - dsh[NUM_W-1:0] : rem_s[g][l];
                end
            end
            always_ff @(posedge i_clk) begin
                r_rem <= n_rem;
                r_den <= den_s[g];
            end
            assign rem_s[g+1] = r_rem;
            assign den_s[g+1] = r_den;
        end
    end

    assign o_valid = vld_s[QUO_W];
    assign o_quo   = quo_s[QUO_W];
    assign o_side  = side_s[QUO_W];

endmodule
`default_nettype wire

// ===== rtl/rmr_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmr_unit
// Vector normalizer: magnitude, window shift, sum of squares, square root,
// rounded division of each component by the length.
// ----------------------------------------------------------------------------
module rmr_unit #(
    parameter int SIDE_W = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  rmr_pkg::t_wide_vec    i_vec,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output rmr_pkg::t_vec         o_vec,
    output logic [SIDE_W-1:0]     o_side
);
    import rmr_pkg::*;

    typedef struct packed {
        logic [2:0][NORM_W-1:0] mag;
        logic [2:0]             neg;
        logic                   zero;
        logic [SIDE_W-1:0]      side;
    } t_sq_side;

    typedef struct packed {
        logic [2:0]        neg;
        logic              zero;
        logic [SIDE_W-1:0] side;
    } t_div_side;

    // stage 1: magnitudes
    logic [2:0][MAG_W-1:0] n1_mag, r1_mag;
    logic [2:0]            n1_neg, r1_neg;
    logic                  r1_v;
    logic [SIDE_W-1:0]     r1_side;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n1_neg[l] = i_vec[l][CROSS_W-1];
            n1_mag[l] = MAG_W'(n1_neg[l] ? (~i_vec[l] + 1'b1) : i_vec[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
        end
        r1_mag  <= n1_mag;
        r1_neg  <= n1_neg;
        r1_side <= i_side;
    end

    // stage 2: leading one of the largest magnitude
    logic [MAG_W-1:0]      orv;
    logic [POS_W-1:0]      n2_pos, r2_pos;
    logic                  r2_zero, r2_v;
    logic [2:0][MAG_W-1:0] r2_mag;
    logic [2:0]            r2_neg;
    logic [SIDE_W-1:0]     r2_side;

    assign orv = r1_mag[0] | r1_mag[1] | r1_mag[2];

    always_comb begin
        n2_pos = '0;
        for (int k = 0; k < MAG_W; k++) begin
            if (orv[k]) begin
                n2_pos = POS_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_pos  <= n2_pos;
        r2_zero <= (orv == '0);
        r2_mag  <= r1_mag;
        r2_neg  <= r1_neg;
        r2_side <= r1_side;
    end

    // stage 3: shift into the window, right shift truncates
    logic [2:0][NORM_W-1:0] n3_mag, r3_mag;
    logic [2:0]             r3_neg;
    logic                   r3_zero, r3_v;
    logic [SIDE_W-1:0]      r3_side;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (r2_pos >= POS_W'(NORM_W - 1)) begin
                n3_mag[l] = NORM_W'(r2_mag[l] >> (r2_pos - POS_W'(NORM_W - 1)));
            end else begin
                n3_mag[l] = NORM_W'(r2_mag[l] << (POS_W'(NORM_W - 1) - r2_pos));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_mag  <= n3_mag;
        r3_neg  <= r2_neg;
        r3_zero <= r2_zero;
        r3_side <= r2_side;
    end

    // stage 4: squares
    logic [2:0][SQ_W-1:0]   r4_sq;
    logic [2:0][NORM_W-1:0] r4_mag;
    logic [2:0]             r4_neg;
    logic                   r4_zero, r4_v;
    logic [SIDE_W-1:0]      r4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
        for (int l = 0; l < 3; l++) begin
            r4_sq[l] <= SQ_W'(r3_mag[l]) * SQ_W'(r3_mag[l]);
        end
        r4_mag  <= r3_mag;
        r4_neg  <= r3_neg;
        r4_zero <= r3_zero;
        r4_side <= r3_side;
    end

    // stage 5: sum of squares
    logic [SUM_W-1:0] r5_sum;
    logic             r5_v;
    t_sq_side         r5_ss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r4_v;
        end
        r5_sum     <= SUM_W'(r4_sq[0]) + SUM_W'(r4_sq[1]) + SUM_W'(r4_sq[2]);
        r5_ss.mag  <= r4_mag;
        r5_ss.neg  <= r4_neg;
        r5_ss.zero <= r4_zero;
        r5_ss.side <= r4_side;
    end

    // length
    logic                      sq_v;
    logic [ROOT_W-1:0]         sq_root;
    logic [$bits(t_sq_side)-1:0] sq_raw;
    t_sq_side                  sq_ss;

    rmr_isqrt #(
        .SIDE_W ($bits(t_sq_side))
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r5_v),
        .i_sum   (r5_sum),
        .i_side  (r5_ss),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_raw)
    );

    assign sq_ss = t_sq_side'(sq_raw);

    // dividend with half the length added for rounding
    logic [2:0][NUM_W-1:0] rd_num;
    logic [ROOT_W-1:0]     rd_den;
    logic                  rd_v;
    t_div_side             rd_ds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_v <= 1'b0;
        end else begin
            rd_v <= sq_v;
        end
        for (int l = 0; l < 3; l++) begin
            rd_num[l] <= (NUM_W'(sq_ss.mag[l]) << FRAC_W) + NUM_W'(sq_root >> 1);
        end
        rd_den     <= sq_root;
        rd_ds.neg  <= sq_ss.neg;
        rd_ds.zero <= sq_ss.zero;
        rd_ds.side <= sq_ss.side;
    end

    logic                         dv_v;
    logic [2:0][QUO_W-1:0]        dv_quo;
    logic [$bits(t_div_side)-1:0] dv_raw;
    t_div_side                    dv_ds;

    rmr_divide #(
        .SIDE_W ($bits(t_div_side))
    ) u_divide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rd_v),
        .i_num   (rd_num),
        .i_den   (rd_den),
        .i_side  (rd_ds),
        .o_valid (dv_v),
        .o_quo   (dv_quo),
        .o_side  (dv_raw)
    );

    assign dv_ds = t_div_side'(dv_raw);

    // signs back on; zero-length vector gives zero
    t_vec              n_out, r_out;
    logic              r_out_v;
    logic [SIDE_W-1:0] r_out_side;

    always_comb begin
        logic [ENTRY_W-1:0] qv;
        for (int l = 0; l < 3; l++) begin
            qv = ENTRY_W'(dv_quo[l]);
            if (dv_ds.zero) begin
                n_out[l] = '0;
            end else if (dv_ds.neg[l]) begin
                n_out[l] = ~qv + 1'b1;
            end else begin
                n_out[l] = qv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= dv_v;
        end
        r_out      <= n_out;
        r_out_side <= dv_ds.side;
    end

    assign o_valid = r_out_v;
    assign o_vec   = r_out;
    assign o_side  = r_out_side;

endmodule
`default_nettype wire

// ===== rtl/rmr_phase.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmr_phase
// One rebuild step: optional cross product a x b, normalize, and optionally
// flip the result when it points away from the old row.
// ----------------------------------------------------------------------------
module rmr_phase #(
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  rmr_pkg::t_vec     i_a,
    input  rmr_pkg::t_vec     i_b,
    input  rmr_pkg::t_vec     i_old,
    input  rmr_pkg::t_ph_ctl  i_ctl,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output rmr_pkg::t_vec     o_vec,
    output logic [SIDE_W-1:0] o_side
);
    import rmr_pkg::*;

    typedef struct packed {
        t_vec              old;
        logic              do_fix;
        logic [SIDE_W-1:0] side;
    } t_fix_side;

    // stage 1: partial products
    logic [5:0][PROD_W-1:0] n1_prod, r1_prod;
    t_vec                   r1_a;
    logic                   r1_cross, r1_v;
    t_fix_side              r1_fs;

    always_comb begin
        logic signed [PROD_W-1:0] ea [3];
        logic signed [PROD_W-1:0] eb [3];
        for (int l = 0; l < 3; l++) begin
            ea[l] = $signed(i_a[l]);
            eb[l] = $signed(i_b[l]);
        end
        n1_prod[0] = ea[1] * eb[2];
        n1_prod[1] = ea[2] * eb[1];
        n1_prod[2] = ea[2] * eb[0];
        n1_prod[3] = ea[0] * eb[2];
        n1_prod[4] = ea[0] * eb[1];
        n1_prod[5] = ea[1] * eb[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
        end
        r1_prod      <= n1_prod;
        r1_a         <= i_a;
        r1_cross     <= i_ctl.do_cross;
        r1_fs.old    <= i_old;
        r1_fs.do_fix <= i_ctl.do_fix;
        r1_fs.side   <= i_side;
    end

    // stage 2: differences, or the row itself
    t_wide_vec n2_vec, r2_vec;
    logic      r2_v;
    t_fix_side r2_fs;

    always_comb begin
        logic signed [CROSS_W-1:0] ep [6];
        logic signed [CROSS_W-1:0] ex [3];
        for (int k = 0; k < 6; k++) begin
            ep[k] = $signed(r1_prod[k]);
        end
        for (int l = 0; l < 3; l++) begin
            ex[l] = $signed(r1_a[l]);
        end
        if (r1_cross) begin
            n2_vec[0] = ep[0] - ep[1];
            n2_vec[1] = ep[2] - ep[3];
            n2_vec[2] = ep[4] - ep[5];
        end else begin
            n2_vec[0] = ex[0];
            n2_vec[1] = ex[1];
            n2_vec[2] = ex[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_vec <= n2_vec;
        r2_fs  <= r1_fs;
    end

    logic                          un_v;
    t_vec                          un_vec;
    logic [$bits(t_fix_side)-1:0]  un_raw;
    t_fix_side                     un_fs;

    rmr_unit #(
        .SIDE_W ($bits(t_fix_side))
    ) u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_v),
        .i_vec   (r2_vec),
        .i_side  (r2_fs),
        .o_valid (un_v),
        .o_vec   (un_vec),
        .o_side  (un_raw)
    );

    assign un_fs = t_fix_side'(un_raw);

    // stage 3: products against the old row
    logic [2:0][PROD_W-1:0] n3_dp, r3_dp;
    t_vec                   r3_u;
    logic                   r3_fix, r3_v;
    logic [SIDE_W-1:0]      r3_side;

    always_comb begin
        logic signed [PROD_W-1:0] eu;
        logic signed [PROD_W-1:0] eo;
        for (int l = 0; l < 3; l++) begin
            eu       = $signed(un_vec[l]);
            eo       = $signed(un_fs.old[l]);
            n3_dp[l] = eu * eo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= un_v;
        end
        r3_dp   <= n3_dp;
        r3_u    <= un_vec;
        r3_fix  <= un_fs.do_fix;
        r3_side <= un_fs.side;
    end

    // stage 4: exact sign of the dot product, flip if negative and do_fix is set
    t_vec              n4_vec, r4_vec;
    logic              r4_v;
    logic [SIDE_W-1:0] r4_side;

    always_comb begin
        logic signed [DOT_W-1:0] d0;
        logic signed [DOT_W-1:0] d1;
        logic signed [DOT_W-1:0] d2;
        logic signed [DOT_W-1:0] dsum;
        d0   = $signed(r3_dp[0]);
        d1   = $signed(r3_dp[1]);
        d2   = $signed(r3_dp[2]);
        dsum = d0 + d1 + d2;
        for (int l = 0; l < 3; l++) begin
            n4_vec[l] = (r3_fix && dsum[DOT_W-1]) ? ~r3_u[l] + 1'b1 : r3_u[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
        r4_vec  <= n4_vec;
        r4_side <= r3_side;
    end

    assign o_valid = r4_v;
    assign o_vec   = r4_vec;
    assign o_side  = r4_side;

endmodule
`default_nettype wire

// ===== test/rotation_matrix_renormalize_unit_checker.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_renormalize_unit_checker
// Watches command and result beats, predicts each renormalized matrix and
// compares it entry by entry with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module rotation_matrix_renormalize_unit_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  rmr_pkg::t_rmr_in  i_cmd,
    input  logic              i_strobe,
    input  rmr_pkg::t_rmr_out i_res,
    output int                o_errors,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import rmr_pkg::*;

    typedef longint t_v3 [3];

    t_rmr_out expected_q[$];

    assign o_pending = expected_q.size();

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_v3 to_unit(t_v3 v);
        longint unsigned mag [3];
        longint unsigned m, total, len, q;
        bit neg [3];
        t_v3 o;
        m = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? -v[i] : v[i];
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) begin
            o = '{0, 0, 0};
            return o;
        end
        while (m >= (64'd1 << 30)) begin
            m >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        while (m < (64'd1 << 29)) begin
            m <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
        end
        total = 0;
        for (int i = 0; i < 3; i++) total += mag[i] * mag[i];
        len = int_sqrt(total);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << FRAC_W) + (len >> 1)) / len;
            o[i] = neg[i] ? -longint'(q) : longint'(q);
        end
        return o;
    endfunction

    // unit(a x b), flipped when it points away from the old row
    function automatic t_v3 rebuild_row(t_v3 a, t_v3 b, t_v3 prev);
        t_v3 c, u;
        longint unsigned pos, ng;
        longint p;
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
        u = to_unit(c);
        pos = 0;
        ng = 0;
        for (int i = 0; i < 3; i++) begin
            p = u[i] * prev[i];
            if (p < 0) ng += -p;
            else pos += p;
        end
        if (ng > pos)
            for (int i = 0; i < 3; i++) u[i] = -u[i];
        return u;
    endfunction

    function automatic t_entry clamp_entry(longint v);
        longint hi, lo;
        hi = (64'sd1 <<< (ENTRY_W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return t_entry'(v);
    endfunction

    function automatic t_rmr_out renormalize(t_rmr_in c);
        t_v3 x, y, z;
        t_rmr_out r;
        x = '{c.in_r0c0, c.in_r0c1, c.in_r0c2};
        y = '{c.in_r1c0, c.in_r1c1, c.in_r1c2};
        z = '{c.in_r2c0, c.in_r2c1, c.in_r2c2};
        case (c.mode)
            MODE_NONE: begin
                y = rebuild_row(z, x, y);
                x = rebuild_row(z, y, x);
                z = rebuild_row(x, y, z);
            end
            MODE_KEEP_X: begin
                x = to_unit(x);
                y = rebuild_row(x, z, y);
                z = rebuild_row(x, y, z);
            end
            MODE_KEEP_Y: begin
                y = to_unit(y);
                x = rebuild_row(y, z, x);
                z = rebuild_row(x, y, z);
            end
            default: begin
                z = to_unit(z);
                x = rebuild_row(y, z, x);
                y = rebuild_row(x, z, y);
            end
        endcase
        r.out_r0c0 = clamp_entry(x[0]);
        r.out_r0c1 = clamp_entry(x[1]);
        r.out_r0c2 = clamp_entry(x[2]);
        r.out_r1c0 = clamp_entry(y[0]);
        r.out_r1c1 = clamp_entry(y[1]);
        r.out_r1c2 = clamp_entry(y[2]);
        r.out_r2c0 = clamp_entry(z[0]);
        r.out_r2c1 = clamp_entry(z[1]);
        r.out_r2c2 = clamp_entry(z[2]);
        return r;
    endfunction

    task automatic check_entry(string name, t_entry exp_v, t_entry got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            o_errors++;
        end
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_rmr_out e;
        if (i_rst_n && i_start && !i_busy)
            expected_q.push_back(renormalize(i_cmd));
        if (i_rst_n && i_strobe) begin
            if (expected_q.size() == 0) begin
                $error("result beat with no outstanding command");
                o_errors++;
            end else begin
                e = expected_q.pop_front();
                check_entry("out_r0c0", e.out_r0c0, i_res.out_r0c0);
                check_entry("out_r0c1", e.out_r0c1, i_res.out_r0c1);
                check_entry("out_r0c2", e.out_r0c2, i_res.out_r0c2);
                check_entry("out_r1c0", e.out_r1c0, i_res.out_r1c0);
                check_entry("out_r1c1", e.out_r1c1, i_res.out_r1c1);
                check_entry("out_r1c2", e.out_r1c2, i_res.out_r1c2);
                check_entry("out_r2c0", e.out_r2c0, i_res.out_r2c0);
                check_entry("out_r2c1", e.out_r2c1, i_res.out_r2c1);
                check_entry("out_r2c2", e.out_r2c2, i_res.out_r2c2);
            end
        end
    end

endmodule

// ===== test/rotation_matrix_renormalize_unit_test.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_renormalize_unit_test
// Drives command beats (directed corners, then near-rotation frames and raw
// noise) through the unit with varying sender gaps; the checker does the rest.
// ----------------------------------------------------------------------------
module rotation_matrix_renormalize_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rmr_pkg::*;

    localparam int RANDOM_BEATS = 400;
    localparam int ONE = 1 << FRAC_W;   // 1.0 in Q2.14

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    t_rmr_in  i_cmd = '0;
    logic     o_strobe;
    t_rmr_out o_res;
    int       errors;
    int       pending;
    int       idle_pct = 0;

    always #2 i_clk = ~i_clk;

    rotation_matrix_renormalize_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    rotation_matrix_renormalize_unit_checker u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_cmd     (i_cmd),
        .i_strobe  (o_strobe),
        .i_res     (o_res),
        .o_errors  (errors),
        .o_pending (pending)
    );

    // Hold one beat until it is taken. Sender gaps are inserted first, with
    // start low, so that start never drops and rises within one step.
    task automatic send_beat(t_rmr_in c);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic send_matrix(t_mode m, int e[9]);
        t_rmr_in c;
        c.mode    = m;
        c.in_r0c0 = t_entry'(e[0]); c.in_r0c1 = t_entry'(e[1]); c.in_r0c2 = t_entry'(e[2]);
        c.in_r1c0 = t_entry'(e[3]); c.in_r1c1 = t_entry'(e[4]); c.in_r1c2 = t_entry'(e[5]);
        c.in_r2c0 = t_entry'(e[6]); c.in_r2c1 = t_entry'(e[7]); c.in_r2c2 = t_entry'(e[8]);
        send_beat(c);
    endtask

    // small perturbation of a signed-permutation frame, plus noise
    function automatic t_rmr_in near_frame();
        t_rmr_in c;
        int p, s [3], jit;
        logic [ENTRY_W-1:0] e [9];
        p = $urandom_range(2);
        jit = 1 << $urandom_range(11);
        for (int r = 0; r < 3; r++) begin
            s[r] = $urandom_range(1) ? ONE : -ONE;
            for (int k = 0; k < 3; k++)
                e[3*r+k] = ENTRY_W'((k == (r + p) % 3 ? s[r] : 0)
                           + int'($urandom_range(2*jit)) - jit);
        end
        c = {t_mode'($urandom_range(3)), e[0], e[1], e[2], e[3], e[4], e[5],
             e[6], e[7], e[8]};
        return c;
    endfunction

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int drain;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners, each mode
        for (int m = 0; m < 4; m++) begin
            send_matrix(t_mode'(m), '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
            send_matrix(t_mode'(m), '{0, 0, 0, 0, 0, 0, 0, 0, 0});
            send_matrix(t_mode'(m), '{32767, -32768, 32767, -32768, 32767,
                                      -32768, 32767, 32767, -32768});
            // parallel rows: zero cross product
            send_matrix(t_mode'(m), '{ONE, 0, 0, ONE, 0, 0, ONE, 0, 0});
            send_matrix(t_mode'(m), '{-1, 0, 0, 0, 1, 0, 0, 0, -1});
            // left-handed frame forces negation of rebuilt rows
            send_matrix(t_mode'(m), '{0, ONE, 0, ONE, 0, 0, 0, 0, ONE});
        end

        // random phases: no gaps, heavy gaps, light gaps
        for (int i = 0; i < RANDOM_BEATS; i++) begin
            t_rmr_in c;
            idle_pct = (i < 130) ? 0 : (i < 270) ? 53 : 10;
            if ($urandom_range(99) < 75) c = near_frame();
            else c = $bits(t_rmr_in)'({$urandom(), $urandom(), $urandom(),
                                       $urandom(), $urandom()});
            send_beat(c);
        end
        start <= 1'b0;

        drain = 0;
        while (pending != 0 && drain < 100_000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (TOTAL_LAT + 20) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rmr_pkg.sv
rtl/rmr_isqrt.sv
rtl/rmr_divide.sv
rtl/rmr_unit.sv
rtl/rmr_phase.sv
rtl/rotation_matrix_renormalize_unit.sv
test/rotation_matrix_renormalize_unit_checker.sv
test/rotation_matrix_renormalize_unit_test.sv
